// ===== rtl/sstf_pkg.sv =====
// sstf_pkg: shared constants, payload structs and the front-to-back command
// for the shortest-seek-first ordering block. No dependencies.
package sstf_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int CYL_W        = 16;
  localparam int TOTAL_W      = 21;
  localparam int DIST_W       = CYL_W + 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  // "nothing found yet" marker for the nearest-distance search
  localparam logic [DIST_W-1:0]  DIST_NONE = {1'b1, {CYL_W{1'b0}}};

  // command queue depth, a power of two so the pointers wrap naturally
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } in_item_t;

  typedef struct packed {
    logic [CYL_W-1:0]   served_cylinder;
    logic [CYL_W-1:0]   step_distance;
    logic [TOTAL_W-1:0] total_seek;
    logic               is_start;
    logic               overflow;
    logic               last_result;
  } out_item_t;

  // one classified request, front to back
  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             store_en;   // table has room, write entry idx
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;      // stored batch size, this request included when stored
    logic             overflow;   // batch dropped at least one request
    logic             last;       // start service after this one
    logic [CYL_W-1:0] start_pos;
  } cmd_t;

endpackage

// ===== rtl/sstf_front.sv =====
// sstf_front: accepts requests and the start position register, classifies
// each request as stored or dropped and pushes a command. Uses sstf_pkg.
module sstf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sstf_pkg::in_item_t in_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data,
  output logic              push,
  output sstf_pkg::cmd_t    push_data,
  input  logic              q_full
);

  logic [sstf_pkg::CNT_W-1:0] count, count_next;
  logic                       dropped;
  logic [sstf_pkg::CYL_W-1:0] start_position;
  logic                       store_en;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;
  assign push      = in_valid && !q_full;

  assign store_en   = count < sstf_pkg::CNT_W'(sstf_pkg::MAX_REQUESTS);
  assign count_next = store_en ? count + 1'b1 : count;

  always_comb begin
    push_data.cylinder  = in_data.request_cylinder;
    push_data.store_en  = store_en;
    push_data.idx       = count[sstf_pkg::IDX_W-1:0];
    push_data.count     = count_next;
    push_data.overflow  = dropped || !store_en;
    push_data.last      = in_data.last_request;
    push_data.start_pos = start_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      dropped        <= 1'b0;
      start_position <= '0;
    end else begin
      if (cfg_valid) begin
        start_position <= cfg_data;
      end
      if (push) begin
        if (in_data.last_request) begin
          count   <= '0;
          dropped <= 1'b0;
        end else begin
          count   <= count_next;
          dropped <= dropped || !store_en;
        end
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= sstf_pkg::CNT_W'(sstf_pkg::MAX_REQUESTS))
    else $error("front: request count beyond table size");

  a_batch_restart: assert property (@(posedge clk) disable iff (rst)
    push && in_data.last_request |=> count == '0 && !dropped)
    else $error("front: batch state not cleared after last request");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("front: command pushed into a full queue");

endmodule

// ===== rtl/sstf_queue.sv =====
// sstf_queue: short command queue between front and back.
// Uses sstf_pkg (cmd_t, QUEUE_DEPTH).
module sstf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sstf_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output sstf_pkg::cmd_t pop_data,
  output logic           empty
);

  sstf_pkg::cmd_t               slots [sstf_pkg::QUEUE_DEPTH];
  logic [sstf_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [sstf_pkg::QFILL_W-1:0] fill;

  assign full     = fill == sstf_pkg::QFILL_W'(sstf_pkg::QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue: push while full");

  a_no_underrun: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue: pop while empty");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= sstf_pkg::QFILL_W'(sstf_pkg::QUEUE_DEPTH))
    else $error("queue: fill count beyond depth");

endmodule

// ===== rtl/sstf_back.sv =====
// sstf_back: request table, nearest-request search and result register.
// Uses sstf_pkg (cmd_t, out_item_t, widths).
module sstf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  sstf_pkg::cmd_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sstf_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_START  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_COMMIT = 4'b1000
  } back_state_t;

  back_state_t state;

  logic [sstf_pkg::CYL_W-1:0]   table_mem [sstf_pkg::MAX_REQUESTS];
  logic [sstf_pkg::MAX_REQUESTS-1:0] served_mask;

  logic [sstf_pkg::CNT_W-1:0]   batch_count, served, issue_idx;
  logic                         ovf;
  logic [sstf_pkg::CYL_W-1:0]   head;
  logic [sstf_pkg::TOTAL_W-1:0] total, total_next;
  logic [sstf_pkg::TOTAL_W:0]   sum;

  logic                         rd_valid, rd_last;
  logic [sstf_pkg::IDX_W-1:0]   rd_idx, best_idx;
  logic [sstf_pkg::CYL_W-1:0]   rd_data, best_cyl, delta;
  logic [sstf_pkg::DIST_W-1:0]  best_d;

  logic out_free, out_load, issue, take, last_step;

  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == ST_START) || (state == ST_COMMIT)) && out_free;
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign issue    = (state == ST_SCAN) && (issue_idx < batch_count);

  assign delta = (rd_data >= head) ? rd_data - head : head - rd_data;
  // strict compare keeps the earliest-loaded entry on ties
  assign take = rd_valid && !served_mask[rd_idx] &&
                ({1'b0, delta} < best_d);

  assign sum        = {1'b0, total} +
                      (sstf_pkg::TOTAL_W + 1)'(best_d[sstf_pkg::CYL_W-1:0]);
  assign total_next = sum[sstf_pkg::TOTAL_W] ? sstf_pkg::TOTAL_MAX
                                             : sum[sstf_pkg::TOTAL_W-1:0];
  assign last_step  = (served + 1'b1) == batch_count;

  // request table: one write port from the queue, one registered read port
  always_ff @(posedge clk) begin
    if (q_pop && q_data.store_en) begin
      table_mem[q_data.idx] <= q_data.cylinder;
    end
    if (issue) begin
      rd_data <= table_mem[issue_idx[sstf_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      rd_valid    <= 1'b0;
      served_mask <= '0;
      batch_count <= '0;
      served      <= '0;
      issue_idx   <= '0;
      best_d      <= sstf_pkg::DIST_NONE;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      rd_valid <= issue;
      if (issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
      if (take) begin
        best_d <= {1'b0, delta};
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop && q_data.last) begin
            batch_count <= q_data.count;
            state       <= ST_START;
          end
        end
        ST_START: begin
          if (out_free) begin
            served_mask <= '0;
            served      <= '0;
            issue_idx   <= '0;
            best_d      <= sstf_pkg::DIST_NONE;
            state       <= (batch_count == '0) ? ST_IDLE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_valid && rd_last) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            served_mask[best_idx] <= 1'b1;
            served                <= served + 1'b1;
            issue_idx             <= '0;
            best_d                <= sstf_pkg::DIST_NONE;
            state                 <= last_step ? ST_IDLE : ST_SCAN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx  <= issue_idx[sstf_pkg::IDX_W-1:0];
      rd_last <= (issue_idx + 1'b1) == batch_count;
    end
    if (take) begin
      best_idx <= rd_idx;
      best_cyl <= rd_data;
    end
    unique case (state)
      ST_IDLE: begin
        if (q_pop && q_data.last) begin
          ovf   <= q_data.overflow;
          head  <= q_data.start_pos;
          total <= '0;
        end
      end
      ST_START: begin
        if (out_free) begin
          out_data.served_cylinder <= head;
          out_data.step_distance   <= '0;
          out_data.total_seek      <= '0;
          out_data.is_start        <= 1'b1;
          out_data.overflow        <= ovf;
          out_data.last_result     <= batch_count == '0;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          head                     <= best_cyl;
          total                    <= total_next;
          out_data.served_cylinder <= best_cyl;
          out_data.step_distance   <= best_d[sstf_pkg::CYL_W-1:0];
          out_data.total_seek      <= total_next;
          out_data.is_start        <= 1'b0;
          out_data.overflow        <= ovf;
          out_data.last_result     <= last_step;
        end
      end
      default: ;
    endcase
  end

  a_commit_found: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT |-> !best_d[sstf_pkg::DIST_W-1])
    else $error("back: commit without an unserved request");

  a_served_bound: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> served < batch_count || state == ST_START)
    else $error("back: served count ran past batch size");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE)
    else $error("back: command taken while a batch is in service");

  a_mask_step: assert property (@(posedge clk) disable iff (rst)
    state == ST_COMMIT && out_free |=>
      $countones(served_mask) == $countones($past(served_mask)) + 1)
    else $error("back: served mask did not gain exactly one entry");

endmodule

// ===== rtl/disk_sstf_order_core.sv =====
// disk_sstf_order_core: top level of the shortest-seek-first request orderer.
// Depends on sstf_pkg, sstf_front, sstf_queue, sstf_back.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  sstf_pkg::in_item_t
//   out      out  out_valid/out_stall sstf_pkg::out_item_t
//   cfg      in   cfg_valid/cfg_ready start position, 16 bits
//
// A request that is not last is taken unless the command queue is full, and
// causes no result. The last request starts service: one start result, then
// for each loaded request a scan of the loaded table entries through the
// single read port, then a commit that emits the nearest unserved one.
// rst is synchronous; the table needs no clearing, entries are read only
// after they were written. out_stall holds the result register, start and
// commit; new requests queue behind a batch in service until the queue fills.
module disk_sstf_order_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sstf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sstf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic           push, q_full, q_pop, q_empty;
  sstf_pkg::cmd_t push_data, pop_data;

  sstf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  sstf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  sstf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/disk_sstf_order_core_tb.sv =====
// disk_sstf_order_core_tb: self-checking bench for the shortest-seek-first orderer.
// Depends on sstf_pkg and disk_sstf_order_core; drives random idle on both
// channels and compares every result transfer against an in-bench scheduler.
`timescale 1ns / 100ps

module disk_sstf_order_core_tb;

  localparam int RAND_ITEMS  = 400;
  localparam int SHOW_MAX    = 10;
  localparam int SETTLE_CYC  = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                si_valid_dummy;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sstf_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sstf_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [15:0]         cfg_data  = '0;

  assign si_valid_dummy = 1'b0;

  disk_sstf_order_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler state mirrored in the bench
  logic [sstf_pkg::CYL_W-1:0] cyl_table [sstf_pkg::MAX_REQUESTS];
  int                         cyl_count  = 0;
  logic                       drop_seen  = 1'b0;
  logic [sstf_pkg::CYL_W-1:0] head_start = '0;

  sstf_pkg::in_item_t  request_q [$];
  sstf_pkg::out_item_t service_q [$];
  int        queued_cnt  = 0;
  int        taken_cnt   = 0;
  int        fail_cnt    = 0;
  int        in_idle_pct = 0;
  int        out_idle_pct = 0;
  int        in_gap      = 0;
  int        stall_left  = 0;
  logic      in_fired    = 1'b0;

  function automatic int pick_gap(input int pct);
    if (int'($urandom_range(99)) < pct) begin
      if ($urandom_range(9) == 0)
        return int'($urandom_range(40, 12));
      return int'($urandom_range(3, 1));
    end
    return 0;
  endfunction

  // load one request; on the last one, lay out the whole service order
  function automatic void sstf_schedule(input sstf_pkg::in_item_t req);
    logic [sstf_pkg::MAX_REQUESTS-1:0] done_mask;
    logic [sstf_pkg::CYL_W-1:0]        head;
    logic [sstf_pkg::TOTAL_W-1:0]      seek;
    logic [sstf_pkg::TOTAL_W:0]        sum;
    logic [sstf_pkg::DIST_W-1:0]       delta;
    logic [sstf_pkg::DIST_W-1:0]       best_dist;
    int                                best_idx;
    sstf_pkg::out_item_t               res;

    if (cyl_count < sstf_pkg::MAX_REQUESTS) begin
      cyl_table[cyl_count] = req.request_cylinder;
      cyl_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!req.last_request)
      return;

    head      = head_start;
    seek      = '0;
    done_mask = '0;
    res.served_cylinder = head;
    res.step_distance   = '0;
    res.total_seek      = '0;
    res.is_start        = 1'b1;
    res.overflow        = drop_seen;
    res.last_result     = (cyl_count == 0);
    service_q = {service_q, res};

    for (int s = 0; s < cyl_count; s++) begin
      best_dist = sstf_pkg::DIST_NONE;
      best_idx  = 0;
      for (int i = 0; i < cyl_count; i++) begin
        if (!done_mask[i]) begin
          delta = (cyl_table[i] >= head)
                  ? sstf_pkg::DIST_W'(cyl_table[i] - head)
                  : sstf_pkg::DIST_W'(head - cyl_table[i]);
          // strict compare keeps the earliest-loaded entry on a tie
          if (delta < best_dist) begin
            best_dist = delta;
            best_idx  = i;
          end
        end
      end
      done_mask[best_idx] = 1'b1;
      head = cyl_table[best_idx];
      sum  = seek + best_dist;
      seek = (sum > sstf_pkg::TOTAL_MAX) ? sstf_pkg::TOTAL_MAX
                                         : sum[sstf_pkg::TOTAL_W-1:0];
      res.served_cylinder = head;
      res.step_distance   = best_dist[sstf_pkg::CYL_W-1:0];
      res.total_seek      = seek;
      res.is_start        = 1'b0;
      res.overflow        = drop_seen;
      res.last_result     = (s + 1 == cyl_count);
      service_q = {service_q, res};
    end

    cyl_count = 0;
    drop_seen = 1'b0;
  endfunction

  function automatic void check_result(input sstf_pkg::out_item_t got);
    sstf_pkg::out_item_t want;
    if (service_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= SHOW_MAX)
        $display("unexpected result: cyl=%0d dist=%0d total=%0d start=%0b",
                 got.served_cylinder, got.step_distance, got.total_seek,
                 got.is_start, " ovf=%0b last=%0b",
                 got.overflow, got.last_result);
      return;
    end
    want = service_q.pop_front();
    if (got.served_cylinder !== want.served_cylinder ||
        got.step_distance   !== want.step_distance   ||
        got.total_seek      !== want.total_seek      ||
        got.is_start        !== want.is_start        ||
        got.overflow        !== want.overflow        ||
        got.last_result     !== want.last_result) begin
      fail_cnt++;
      if (fail_cnt <= SHOW_MAX)
        $display("mismatch: exp cyl=%0d dist=%0d total=%0d start=%0b ovf=%0b last=%0b",
                 want.served_cylinder, want.step_distance, want.total_seek,
                 want.is_start, want.overflow, want.last_result,
                 " | got cyl=%0d dist=%0d total=%0d start=%0b ovf=%0b last=%0b",
                 got.served_cylinder, got.step_distance, got.total_seek,
                 got.is_start, got.overflow, got.last_result);
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    in_fired <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall)
      check_result(out_data);
    if (!rst && in_valid && !in_stall) begin
      sstf_schedule(in_data);
      taken_cnt++;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_data  <= request_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= pick_gap(in_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin : out_pacer
    int len;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      len = pick_gap(out_idle_pct);
      out_stall  <= (len > 0);
      stall_left <= (len > 0) ? len - 1 : 0;
    end
  end

  task automatic write_start(input logic [15:0] pos);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= pos;
    do @(posedge clk); while (!cfg_ready);
    head_start = pos;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_request(input logic [15:0] cyl, input logic last);
    sstf_pkg::in_item_t req;
    req.request_cylinder = cyl;
    req.last_request     = last;
    request_q = {request_q, req};
    queued_cnt++;
  endtask

  // hold off the sender until every queued transfer and result is through
  task automatic drain();
    do @(negedge clk); while (taken_cnt != queued_cnt || service_q.size() != 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic add_batch(input int n);
    int          flavor;
    logic [15:0] cyl;
    flavor = int'($urandom_range(2));
    for (int k = 0; k < n; k++) begin
      case (flavor)
        0: cyl = 16'($urandom_range(65535));
        // near the head: lots of ties and duplicates
        1: cyl = head_start - 16'd4 + 16'($urandom_range(8));
        default: begin
          case ($urandom_range(3))
            0: cyl = 16'h0000;
            1: cyl = 16'hffff;
            2: cyl = 16'h8000;
            default: cyl = 16'($urandom_range(65535));
          endcase
        end
      endcase
      add_request(cyl, k == n - 1);
    end
  endtask

  function automatic int pick_batch_size();
    int r;
    r = int'($urandom_range(99));
    if (r < 70)
      return int'($urandom_range(6, 1));
    if (r < 92)
      return int'($urandom_range(31, 7));
    // full table, then past it (last request itself dropped above 32)
    return int'($urandom_range(sstf_pkg::MAX_REQUESTS + 4, sstf_pkg::MAX_REQUESTS));
  endfunction

  initial begin
    int target;
    int nb;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    in_idle_pct  = 30;
    out_idle_pct = 30;

    // start position still at its reset value; duplicates and extremes
    add_request(16'hffff, 1'b0);
    add_request(16'h0000, 1'b0);
    add_request(16'h8000, 1'b0);
    add_request(16'h0000, 1'b1);
    drain();

    write_start(16'hffff);
    add_request(16'h1234, 1'b0);
    add_request(16'hffff, 1'b0);
    add_request(16'h1234, 1'b1);
    drain();

    // equal distance both ways: earlier request goes first
    write_start(16'd100);
    add_request(16'd110, 1'b0);
    add_request(16'd90,  1'b0);
    add_request(16'd110, 1'b1);
    drain();

    write_start(16'h0000);
    add_request(16'd7, 1'b1);
    drain();

    write_start(16'h8000);
    add_request(16'h0000, 1'b0);
    add_request(16'hffff, 1'b1);
    drain();

    target = queued_cnt + RAND_ITEMS;
    while (queued_cnt < target) begin
      case ($urandom_range(3))
        0: write_start(16'h0000);
        1: write_start(16'hffff);
        default: write_start(16'($urandom_range(65535)));
      endcase
      case ($urandom_range(2))
        0: in_idle_pct = 0;
        1: in_idle_pct = 25;
        default: in_idle_pct = 60;
      endcase
      case ($urandom_range(2))
        0: out_idle_pct = 0;
        1: out_idle_pct = 25;
        default: out_idle_pct = 60;
      endcase
      nb = int'($urandom_range(3, 1));
      for (int b = 0; b < nb; b++)
        add_batch(pick_batch_size());
      drain();
    end

    repeat (50) @(negedge clk);
    if (fail_cnt == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sstf_pkg.sv
rtl/sstf_front.sv
rtl/sstf_queue.sv
rtl/sstf_back.sv
rtl/disk_sstf_order_core.sv
tb/disk_sstf_order_core_tb.sv
